@@ src/assert_macros.svh @@
// Assertion macros for the transmit queue RTL.
// Depends on nothing. Checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

@@ src/dptq_pkg.sv @@
// Package for the deadline priority transmit queue: sizes, codes, cell types.
// Depends on nothing.
`default_nettype none
package dptq_pkg;
   localparam int QueueDepth     = 4;
   localparam int SlotW          = 2;
   localparam int PriorityLevels = 5;
   localparam int MaxPacketBytes = 255;
   localparam int NumDefaults    = 5;

   localparam logic [1:0] OP_PUSH_ABS = 2'd0;
   localparam logic [1:0] OP_PUSH_DEF = 2'd1;
   localparam logic [1:0] OP_POP      = 2'd2;
   localparam logic [1:0] OP_CLEAR    = 2'd3;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_INVALID  = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_EMPTY    = 3'd3;
   localparam logic [2:0] ST_TOOSMALL = 3'd4;

   // cell commands
   localparam logic [2:0] CMD_NONE   = 3'd0;
   localparam logic [2:0] CMD_EXPIRE = 3'd1;
   localparam logic [2:0] CMD_SCAN   = 3'd2;
   localparam logic [2:0] CMD_WRITE  = 3'd3;
   localparam logic [2:0] CMD_KILL   = 3'd4;
   localparam logic [2:0] CMD_CLEAR  = 3'd5;

   typedef struct packed {
      logic        valid;
      logic [2:0]  prio;
      logic [63:0] deadline;
      logic [31:0] enq_time;
      logic [63:0] age;
      logic [9:0]  length;
      logic [15:0] tag;
   } entry_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic [2:0]       cmd;
      logic [SlotW-1:0] sel;
      logic [63:0]      time_base;
      entry_type        wr;
   } cell_ctl_type;

   // scan token handed from cell to cell
   typedef struct packed {
      logic             any_valid;
      logic             any_free;
      logic [SlotW-1:0] free_slot;
      logic [SlotW-1:0] best_slot;
      logic [2:0]       best_prio;
      logic [63:0]      best_age;
      logic [SlotW-1:0] low_slot;
      logic [2:0]       low_prio;
      logic [63:0]      low_age;
      logic [2:0]       count;
      logic [2:0]       expired;
   } scan_type;
endpackage
`default_nettype wire

@@ src/dptq_cell.sv @@
// One queue slot: holds one descriptor and folds it into the scan token.
// Depends on dptq_pkg.
`default_nettype none
module dptq_cell (
   input  wire                         clock,
   input  wire                         reset,
   input  wire [dptq_pkg::SlotW-1:0]   my_slot,
   input  dptq_pkg::cell_ctl_type      ctl,
   input  dptq_pkg::scan_type          scan_in,
   output dptq_pkg::scan_type          scan_out,
   output dptq_pkg::entry_type         entry
);
   import dptq_pkg::*;

   entry_type e_ff, e_in;
   logic      live;
   logic      better, lower;

   assign entry = e_ff;
   assign live  = e_ff.valid;

   always_comb begin
      better = (e_ff.prio < scan_in.best_prio) ||
               (e_ff.prio == scan_in.best_prio && e_ff.age < scan_in.best_age);
      lower  = (e_ff.prio > scan_in.low_prio) ||
               (e_ff.prio == scan_in.low_prio && e_ff.age < scan_in.low_age);
      scan_out = scan_in;
      if (live) begin
         scan_out.count = scan_in.count + 3'd1;
         if (!scan_in.any_valid || better) begin
            scan_out.best_slot = my_slot;
            scan_out.best_prio = e_ff.prio;
            scan_out.best_age  = e_ff.age;
         end
         if (!scan_in.any_valid || lower) begin
            scan_out.low_slot = my_slot;
            scan_out.low_prio = e_ff.prio;
            scan_out.low_age  = e_ff.age;
         end
         scan_out.any_valid = 1'b1;
      end else if (!scan_in.any_free) begin
         scan_out.any_free  = 1'b1;
         scan_out.free_slot = my_slot;
      end
      if (ctl.cmd == CMD_EXPIRE && live && ctl.time_base >= e_ff.deadline)
         scan_out.expired = scan_in.expired + 3'd1;
   end

   always_comb begin
      e_in = e_ff;
      case (ctl.cmd)
         CMD_EXPIRE: if (live && ctl.time_base >= e_ff.deadline) e_in.valid = 1'b0;
         CMD_WRITE:  if (ctl.sel == my_slot) e_in = ctl.wr;
         CMD_KILL:   if (ctl.sel == my_slot) e_in.valid = 1'b0;
         CMD_CLEAR:  e_in.valid = 1'b0;
         default:    e_in = e_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) e_ff.valid <= 1'b0;
      else e_ff <= e_in;
   end
endmodule
`default_nettype wire

@@ src/deadline_priority_tx_queue.sv @@
// Top level of the deadline priority transmit queue: controller, cell row, stats.
// Depends on dptq_pkg, dptq_cell and assert_macros.svh.
//
//  channel  | direction | handshake       | payload
//  req_     | in        | valid / stall   | opcode, time, priority, deadline, tag, length
//  rsp_     | out       | valid / stall   | status, slot, preempted, counts, latency stats
//  csr_     | in        | write enable    | default deadline registers 0..4
//
// One request at a time: a rejected push goes straight to the response state,
// clear goes through the clear state, a pop or a push that writes nothing through
// expire and decide, and a push that writes also through write, after renumber
// when ages must be renumbered. Expire, scan and update share the single cell row.
// Reset is synchronous and clears the table valid bits, statistics and time base;
// req_stall stays high during reset. A waiting response holds in its output
// register while rsp_stall is high; the next request is taken from the cycle
// after the response has gone.
`default_nettype none
`include "assert_macros.svh"
module deadline_priority_tx_queue (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [1:0]  req_opcode,
   input  wire  [31:0] req_current_time_ms,
   input  wire  [2:0]  req_priority_req,
   input  wire  [31:0] req_deadline_ms_in,
   input  wire  [15:0] req_packet_tag,
   input  wire  [9:0]  req_packet_length,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [1:0]  rsp_slot_index,
   output logic        rsp_preempted,
   output logic [2:0]  rsp_expired_count,
   output logic [15:0] rsp_out_tag,
   output logic [9:0]  rsp_out_length,
   output logic [31:0] rsp_wait_ms,
   output logic [28:0] rsp_avg_wait_ms,
   output logic [31:0] rsp_peak_wait_ms,
   output logic [2:0]  rsp_queued_count,
   input  wire         csr_write_enable,
   input  wire  [2:0]  csr_index,
   input  wire  [30:0] csr_write_data
);
   import dptq_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXPIRE = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_RENUM  = 3'd3;
   localparam logic [2:0] S_WRITE  = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;
   localparam logic [2:0] S_RESP   = 3'd6;

   logic [2:0]  state_ff, state_in;
   logic [30:0] dflt_ff [NumDefaults];

   // captured request
   logic [1:0]  op_ff;
   logic [31:0] now_ff;
   logic [2:0]  prio_ff;
   logic [31:0] dl_ff;
   logic [15:0] tag_ff;
   logic [9:0]  len_ff;

   logic [63:0] tb_ff, tb_in;
   logic [63:0] next_age_ff, next_age_in;
   logic [31:0] avg_ff, avg_in, max_ff, max_in;
   logic [2:0]  exp_ff;
   logic [SlotW-1:0] slot_ff;
   logic        pre_ff;
   logic [2:0]  renum_ff;   // live entries still to renumber

   logic        rv_ff;
   logic [2:0]  r_status_ff, r_exp_ff, r_cnt_ff;
   logic [1:0]  r_slot_ff;
   logic        r_pre_ff;
   logic [15:0] r_tag_ff;
   logic [9:0]  r_len_ff;
   logic [31:0] r_lat_ff;

   cell_ctl_type ctl;
   scan_type     chain [QueueDepth+1];
   entry_type    ents  [QueueDepth];

   // renumber pick: oldest live entry with age at or above the rank floor
   logic [63:0] renum_floor_ff;
   logic [SlotW-1:0] pick;
   logic        pick_ok;

   logic        accept;
   logic        bad_arg;
   logic [31:0] target, delta;
   logic [31:0] d_lat, lat, decayed;
   logic [32:0] avg_sum;

   assign accept    = req_valid && !req_stall;
   assign req_stall = reset || (state_ff != S_IDLE) || rv_ff;

   assign bad_arg = (req_packet_length == 10'd0) ||
                    (req_packet_length > 10'(MaxPacketBytes)) ||
                    (req_priority_req >= 3'(PriorityLevels)) ||
                    (req_opcode == OP_PUSH_DEF && req_priority_req >= 3'(NumDefaults));

   assign target = (op_ff == OP_PUSH_DEF) ? now_ff + {1'b0, dflt_ff[prio_ff]} : dl_ff;
   assign delta  = target - now_ff;

   always_comb begin
      pick_ok = 1'b0;
      pick    = '0;
      for (int i = 0; i < QueueDepth; i++) begin
         if (ents[i].valid && ents[i].age >= renum_floor_ff &&
             (!pick_ok || ents[i].age < ents[pick].age)) begin
            pick_ok = 1'b1;
            pick    = SlotW'(i);
         end
      end
   end

   // cell row
   assign chain[0] = '{any_valid: 1'b0, any_free: 1'b0, free_slot: '0, best_slot: '0,
                       best_prio: '0, best_age: '0, low_slot: '0, low_prio: '0,
                       low_age: '0, count: '0, expired: '0};
   for (genvar g = 0; g < QueueDepth; g++) begin : g_cell
      dptq_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .my_slot  (SlotW'(g)),
         .ctl      (ctl),
         .scan_in  (chain[g]),
         .scan_out (chain[g+1]),
         .entry    (ents[g])
      );
   end

   scan_type sc;
   assign sc = chain[QueueDepth];

   always_comb begin
      d_lat   = now_ff - ents[sc.best_slot].enq_time;
      lat     = (d_lat != 32'd0 && !d_lat[31]) ? d_lat : 32'd0;
      decayed = avg_ff - (avg_ff >> 3);
      avg_sum = {1'b0, decayed} + {1'b0, lat};
   end

   always_comb begin
      ctl           = '0;
      ctl.time_base = tb_ff;
      ctl.cmd       = CMD_NONE;
      state_in      = state_ff;
      tb_in         = tb_ff;
      next_age_in   = next_age_ff;
      avg_in        = avg_ff;
      max_in        = max_ff;
      case (state_ff)
         S_IDLE: if (accept) begin
            if (req_opcode == OP_CLEAR) state_in = S_DONE;
            else if (req_opcode != OP_POP && bad_arg) state_in = S_RESP;
            else begin
               tb_in = tb_ff + {32'd0, req_current_time_ms - tb_ff[31:0]};
               state_in = S_EXPIRE;
            end
         end
         S_EXPIRE: begin
            ctl.cmd  = CMD_EXPIRE;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = S_RESP;
            if (op_ff == OP_POP) begin
               if (sc.any_valid && ents[sc.best_slot].length <= len_ff) begin
                  ctl.cmd = CMD_KILL;
                  ctl.sel = sc.best_slot;
                  max_in  = (lat > max_ff) ? lat : max_ff;
                  avg_in  = avg_sum[32] ? 32'hFFFF_FFFF : avg_sum[31:0];
               end
            end else if (delta != 32'd0 && !delta[31] &&
                         (sc.any_free || sc.low_prio > prio_ff)) begin
               if (!sc.any_free) begin
                  ctl.cmd = CMD_KILL;
                  ctl.sel = sc.low_slot;
               end
               state_in = (next_age_ff == 64'hFFFF_FFFF_FFFF_FFFF) ? S_RENUM : S_WRITE;
               if (next_age_ff == 64'hFFFF_FFFF_FFFF_FFFF) next_age_in = '0;
            end
         end
         S_RENUM: begin
            // give the oldest unranked entry the next rank
            if (pick_ok && renum_ff != 3'd0) begin
               ctl.cmd        = CMD_WRITE;
               ctl.sel        = pick;
               ctl.wr         = ents[pick];
               ctl.wr.age     = next_age_ff;
               next_age_in    = next_age_ff + 64'd1;
            end else state_in = S_WRITE;
         end
         S_WRITE: begin
            ctl.cmd         = CMD_WRITE;
            ctl.sel         = slot_ff;
            ctl.wr.valid    = 1'b1;
            ctl.wr.prio     = prio_ff;
            ctl.wr.deadline = tb_ff + {32'd0, delta};
            ctl.wr.enq_time = now_ff;
            ctl.wr.age      = next_age_ff;
            ctl.wr.length   = len_ff;
            ctl.wr.tag      = tag_ff;
            next_age_in     = next_age_ff + 64'd1;
            state_in        = S_RESP;
         end
         S_DONE: begin
            ctl.cmd     = CMD_CLEAR;
            avg_in      = '0;
            max_in      = '0;
            next_age_in = '0;
            state_in    = S_RESP;
         end
         S_RESP:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         tb_ff       <= '0;
         next_age_ff <= '0;
         avg_ff      <= '0;
         max_ff      <= '0;
         rv_ff       <= 1'b0;
         dflt_ff[0]  <= 31'd1000;
         dflt_ff[1]  <= 31'd2000;
         dflt_ff[2]  <= 31'd5000;
         dflt_ff[3]  <= 31'd10000;
         dflt_ff[4]  <= 31'd30000;
      end else begin
         state_ff    <= state_in;
         tb_ff       <= tb_in;
         next_age_ff <= next_age_in;
         avg_ff      <= avg_in;
         max_ff      <= max_in;
         if (csr_write_enable && csr_index < 3'(NumDefaults))
            dflt_ff[csr_index] <= csr_write_data;
         if (state_ff == S_RESP) rv_ff <= 1'b1;
         else if (rv_ff && !rsp_stall) rv_ff <= 1'b0;
      end
   end

   // working registers and response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_opcode;
         now_ff  <= req_current_time_ms;
         prio_ff <= req_priority_req;
         dl_ff   <= req_deadline_ms_in;
         tag_ff  <= req_packet_tag;
         len_ff  <= req_packet_length;
         exp_ff  <= '0;
         pre_ff  <= 1'b0;
         slot_ff <= '0;
         r_status_ff <= (req_opcode == OP_CLEAR || req_opcode == OP_POP || !bad_arg) ?
                        ST_OK : ST_INVALID;
         r_tag_ff <= '0;
         r_len_ff <= '0;
         r_lat_ff <= '0;
      end
      if (state_ff == S_EXPIRE) exp_ff <= sc.expired;
      if (state_ff == S_DECIDE) begin
         renum_ff       <= sc.count - (sc.any_free ? 3'd0 : 3'd1);
         renum_floor_ff <= '0;
         if (op_ff == OP_POP) begin
            if (!sc.any_valid) r_status_ff <= ST_EMPTY;
            else if (ents[sc.best_slot].length > len_ff) r_status_ff <= ST_TOOSMALL;
            else begin
               slot_ff  <= sc.best_slot;
               r_tag_ff <= ents[sc.best_slot].tag;
               r_len_ff <= ents[sc.best_slot].length;
               r_lat_ff <= lat;
            end
         end else if (delta == 32'd0 || delta[31]) r_status_ff <= ST_INVALID;
         else if (sc.any_free) slot_ff <= sc.free_slot;
         else if (sc.low_prio > prio_ff) begin
            slot_ff <= sc.low_slot;
            pre_ff  <= 1'b1;
         end else r_status_ff <= ST_FULL;
      end
      if (state_ff == S_RENUM && pick_ok && renum_ff != 3'd0) begin
         renum_ff       <= renum_ff - 3'd1;
         renum_floor_ff <= ents[pick].age + 64'd1;
      end
      if (state_ff == S_RESP) begin
         r_exp_ff  <= exp_ff;
         r_slot_ff <= (r_status_ff == ST_OK) ? slot_ff : 2'd0;
         r_pre_ff  <= pre_ff && (r_status_ff == ST_OK);
         r_cnt_ff  <= sc.count;
      end
   end

   assign rsp_valid          = rv_ff;
   assign rsp_status         = r_status_ff;
   assign rsp_slot_index     = r_slot_ff;
   assign rsp_preempted      = r_pre_ff;
   assign rsp_expired_count  = r_exp_ff;
   assign rsp_out_tag        = r_tag_ff;
   assign rsp_out_length     = r_len_ff;
   assign rsp_wait_ms        = r_lat_ff;
   assign rsp_avg_wait_ms    = avg_ff[31:3];
   assign rsp_peak_wait_ms   = max_ff;
   assign rsp_queued_count   = r_cnt_ff;

   `ASSERT_IMPLY(a_no_accept_busy, clock, reset, state_ff != S_IDLE, !accept)
   `ASSERT_NEXT(a_resp_follows, clock, reset, state_ff == S_RESP, rsp_valid)
   `ASSERT_IMPLY(a_count_bound, clock, reset, rsp_valid, rsp_queued_count <= 3'(QueueDepth))
endmodule
`default_nettype wire
